@@ hdl/crs_pkg.sv @@
// Shared types and constants for the colour run segmenter.
// Used by crs_ctrl, crs_dp and the top level; depends on nothing else.
package crs_pkg;

  // Build limits of the image geometry
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned WIDTH_CAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
  localparam int unsigned HEIGHT_CAP = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;

  localparam logic [12:0] WIDTH_LIMIT = 13'(WIDTH_CAP);
  localparam logic [11:0] ROW_LIMIT   = 12'(HEIGHT_CAP - 1);

  // Field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned COMP_W  = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;

  // Similarity modes
  localparam logic [1:0] MODE_EUCLID = 2'd0;
  localparam logic [1:0] MODE_MANH   = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;

  // Register reset values
  localparam logic [1:0]  MODE_RESET      = MODE_MANH;
  localparam logic [9:0]  THRESHOLD_RESET = 10'd900;
  localparam logic [12:0] WIDTH_RESET     = 13'd640;

  // Fixed-point scale factors of the similarity tests
  localparam logic [9:0]  FULL_TENTHS = 10'd1000;
  localparam logic [9:0]  MANH_FULL   = 10'd765;
  localparam logic [17:0] EUCLID_FULL = 18'd195075;
  localparam logic [19:0] SQ_SCALE    = 20'd1000000;

  // Last wait count; the controller then reads the registered break decision
  localparam logic [2:0] CALC_LAST = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // latch pixel, apply frame start
    logic open_first;  // first pixel of a row opens the run
    logic emit_break;  // emit the broken run, open a new one here
    logic emit_end;    // emit the row's final run, wrap the column
    logic advance;     // step to the next column
  } crs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic col_zero;
    logic brk;
    logic row_end;
    logic out_free;
  } crs_stat_t;

  // One result segment
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row;
    logic [11:0] seg_end;
    logic [11:0] seg_start;
  } crs_seg_t;

endpackage

@@ hdl/crs_ctrl.sv @@
// Sequencing state machine of the colour run segmenter.
// Depends on crs_pkg; drives crs_dp through crs_cmd_t and reads crs_stat_t.
module crs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  crs_pkg::crs_stat_t stat,
  output crs_pkg::crs_cmd_t  cmd
);
  import crs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_CALC    = 5'b00010,
    ST_DECIDE  = 5'b00100,
    ST_SEG_BRK = 5'b01000,
    ST_SEG_END = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [2:0] calc_cnt, calc_cnt_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    calc_cnt_next = calc_cnt;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          calc_cnt_next = '0;
          state_next    = ST_CALC;
        end
      end
      ST_CALC: begin
        calc_cnt_next = calc_cnt + 3'd1;
        if (calc_cnt == CALC_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.col_zero) begin
          cmd.open_first = 1'b1;
          if (stat.row_end) begin
            state_next = ST_SEG_END;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end
        end else if (stat.brk) begin
          state_next = ST_SEG_BRK;
        end else if (stat.row_end) begin
          state_next = ST_SEG_END;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SEG_BRK: begin
        if (stat.out_free) begin
          cmd.emit_break = 1'b1;
          if (stat.row_end) begin
            state_next = ST_SEG_END;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      ST_SEG_END: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      calc_cnt <= '0;
    end else begin
      state    <= state_next;
      calc_cnt <= calc_cnt_next;
    end
  end

endmodule

@@ hdl/crs_dp.sv @@
// Datapath of the colour run segmenter: configuration, run state, the
// similarity pipeline and the output register. Depends on crs_pkg.
module crs_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic [23:0]        pix_in,
  input  logic               frame_start,
  input  crs_pkg::crs_cmd_t  cmd,
  output crs_pkg::crs_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output crs_pkg::crs_seg_t  out_seg,
  output logic               out_last
);
  import crs_pkg::*;

  // Configuration
  logic [1:0]  mode;
  logic [9:0]  thr;
  logic [12:0] row_width;

  // Run state
  logic [23:0] pix;
  logic [23:0] run_color;
  logic [11:0] run_begin;
  logic [11:0] column;
  logic [11:0] row_count;

  // Pipeline registers
  logic [7:0]  dr, dg, db;
  logic [9:0]  man_d;
  logic [17:0] d2, n1, n2, dot;
  logic [19:0] aa, tt;
  logic        brk_m;
  logic [37:0] lhs_e, rhs_e;
  logic [35:0] dot2, nn;
  logic        zero_norm;
  logic        brk_e;
  logic [37:0] cl_lo, cl_hi, cr_lo, cr_hi;
  logic [56:0] cos_l, cos_r;
  logic        brk;

  logic [7:0]  r0, g0, b0, r1, g1, b1;
  logic [9:0]  a_term;
  logic [12:0] w_eff;
  logic        row_end;
  logic        thr_nz;

  assign r0 = run_color[23:16];
  assign g0 = run_color[15:8];
  assign b0 = run_color[7:0];
  assign r1 = pix[23:16];
  assign g1 = pix[15:8];
  assign b1 = pix[7:0];
  assign a_term = FULL_TENTHS - thr;
  assign thr_nz = (thr != 10'd0);

  // Clamp the row width
  always_comb begin
    if (row_width == 13'd0) begin
      w_eff = 13'd1;
    end else if (row_width > WIDTH_LIMIT) begin
      w_eff = WIDTH_LIMIT;
    end else begin
      w_eff = row_width;
    end
  end

  assign row_end = ({1'b0, column} + 13'd1) >= w_eff;

  assign stat.col_zero = (column == 12'd0);
  assign stat.brk      = brk;
  assign stat.row_end  = row_end;
  assign stat.out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RESET;
      thr       <= THRESHOLD_RESET;
      row_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode      <= cfg_data[1:0];
        REG_THRESHOLD: thr       <= cfg_data[9:0];
        REG_WIDTH:     row_width <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Stage 1: component differences
  always_ff @(posedge clk) begin
    dr    <= (r0 > r1) ? r0 - r1 : r1 - r0;
    dg    <= (g0 > g1) ? g0 - g1 : g1 - g0;
    db    <= (b0 > b1) ? b0 - b1 : b1 - b0;
    man_d <= 10'((r0 > r1) ? r0 - r1 : r1 - r0) + 10'((g0 > g1) ? g0 - g1 : g1 - g0)
           + 10'((b0 > b1) ? b0 - b1 : b1 - b0);
  end

  // Stage 2: squared sums, norms, dot product, manhattan test
  always_ff @(posedge clk) begin
    d2    <= 18'(16'(dr) * 16'(dr)) + 18'(16'(dg) * 16'(dg)) + 18'(16'(db) * 16'(db));
    n1    <= 18'(16'(r0) * 16'(r0)) + 18'(16'(g0) * 16'(g0)) + 18'(16'(b0) * 16'(b0));
    n2    <= 18'(16'(r1) * 16'(r1)) + 18'(16'(g1) * 16'(g1)) + 18'(16'(b1) * 16'(b1));
    dot   <= 18'(16'(r0) * 16'(r1)) + 18'(16'(g0) * 16'(g1)) + 18'(16'(b0) * 16'(b1));
    aa    <= 20'(a_term) * 20'(a_term);
    tt    <= 20'(thr) * 20'(thr);
    brk_m <= (20'(FULL_TENTHS) * 20'(MANH_FULL - man_d)) < (20'(thr) * 20'(MANH_FULL));
  end

  // Stage 3: euclidean products, squared dot and norm product
  always_ff @(posedge clk) begin
    lhs_e     <= 38'(aa) * 38'(EUCLID_FULL);
    rhs_e     <= 38'(d2) * 38'(SQ_SCALE);
    dot2      <= 36'(dot) * 36'(dot);
    nn        <= 36'(n1) * 36'(n2);
    zero_norm <= (n1 == 18'd0) || (n2 == 18'd0);
  end

  // Stage 4: euclidean test, cosine partial products
  always_ff @(posedge clk) begin
    brk_e <= (thr > FULL_TENTHS) || (lhs_e < rhs_e);
    cl_lo <= 38'(dot2[17:0]) * 38'(SQ_SCALE);
    cl_hi <= 38'(dot2[35:18]) * 38'(SQ_SCALE);
    cr_lo <= 38'(tt) * 38'(nn[17:0]);
    cr_hi <= 38'(tt) * 38'(nn[35:18]);
  end

  // Stage 5: combine partial products
  always_ff @(posedge clk) begin
    cos_l <= 57'({cl_hi[37:0], 18'd0}) + 57'(cl_lo);
    cos_r <= 57'({cr_hi[37:0], 18'd0}) + 57'(cr_lo);
  end

  // Stage 6: select the break decision by mode
  always_ff @(posedge clk) begin
    unique case (mode)
      MODE_EUCLID: brk <= brk_e;
      MODE_MANH:   brk <= brk_m;
      MODE_COSINE: brk <= zero_norm ? thr_nz : (cos_l < cos_r);
      default:     brk <= thr_nz;
    endcase
  end

  // Run state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      run_begin <= '0;
      run_color <= '0;
      column    <= '0;
      row_count <= '0;
    end else begin
      if (cmd.accept && frame_start) begin
        column    <= '0;
        row_count <= '0;
      end
      if (cmd.open_first) begin
        run_begin <= '0;
        run_color <= pix;
      end
      if (cmd.emit_break) begin
        run_begin <= column;
        run_color <= pix;
      end
      if (cmd.advance) begin
        column <= column + 12'd1;
      end
      if (cmd.emit_end) begin
        column <= '0;
        if (row_count < ROW_LIMIT) begin
          row_count <= row_count + 12'd1;
        end
      end
    end
  end

  // Hold the accepted pixel
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix <= pix_in;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit_break) begin
      out_seg.seg_start <= run_begin;
      out_seg.seg_end   <= column - 12'd1;
      out_seg.row       <= row_count;
      out_seg.red       <= r0;
      out_seg.green     <= g0;
      out_seg.blue      <= b0;
      out_last          <= !row_end;
    end else if (cmd.emit_end) begin
      out_seg.seg_start <= run_begin;
      out_seg.seg_end   <= column;
      out_seg.row       <= row_count;
      out_seg.red       <= r0;
      out_seg.green     <= g0;
      out_seg.blue      <= b0;
      out_last          <= 1'b1;
    end
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_break || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/color_run_segmenter.sv @@
// Colour run segmenter top level: stream ports, field packing, and the
// controller and datapath instances. Depends on crs_pkg, crs_ctrl and crs_dp.
//
// Splits a raster stream of RGB pixels into horizontal runs of similar colour
// and emits one segment per run (start column, end column, row, colour of the
// run's first pixel). A pixel is taken only while the block is idle; each one
// then occupies the block until its break decision is made and each segment it
// causes (zero, one or two) is registered for output, longer when the output
// side stalls. Every pixel passes the six-stage similarity pipeline before the
// break decision, since the next comparison needs the run colour this one
// leaves. A finished segment waits in the output register while the next pixel
// is taken. Configuration writes belong between pixels, when the block is idle.
module color_run_segmenter (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pix_red, pix_green, pix_blue
  input  logic        s_axis_tuser,   // frame_start
  // Segment output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // seg_start, seg_end, seg_row, seg_red,
                                      // seg_green, seg_blue, zero padding
  output logic        m_axis_tlast    // last_of_run
);
  import crs_pkg::*;

  crs_cmd_t  cmd;
  crs_stat_t stat;
  crs_seg_t  seg;
  logic      last;

  // Sequencer
  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath; pixel packed as red, green, blue from bit 23 down
  crs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_in      ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .frame_start (s_axis_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_seg     (seg),
    .out_last    (last)
  );

  // Pack the segment, first field lowest
  assign m_axis_tdata = {4'd0, seg.blue, seg.green, seg.red, seg.row,
                         seg.seg_end, seg.seg_start};
  assign m_axis_tlast = last;

endmodule

@@ test/crs_checker.sv @@
`timescale 1ns / 1ps
// Segment checker for the colour run segmenter: follows the configuration writes,
// predicts the segments of every pixel transaction and compares them in order.
// Depends on crs_pkg.
module crs_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,     // pix_red, pix_green, pix_blue
  input  logic        s_tuser,     // frame_start
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,     // seg_start, seg_end, seg_row, seg_red,
                                   // seg_green, seg_blue, zero padding
  input  logic        m_tlast,     // last_of_run
  output int          fail_count,
  output int          outstanding
);
  import crs_pkg::*;

  typedef struct packed {
    logic     last;
    crs_seg_t seg;
  } seg_item_t;

  seg_item_t   pending_segs[$];
  int          mismatches = 0;
  int          queued = 0;

  // Shadow copy of the registers
  logic [1:0]  sim_mode;
  logic [9:0]  thr_tenths;
  logic [12:0] row_width;

  // Shadow copy of the run state
  logic [11:0] run_begin;
  logic [11:0] column;
  logic [11:0] row_count;
  logic [7:0]  run_red, run_green, run_blue;

  assign fail_count  = mismatches;
  assign outstanding = queued;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  // True when the pixel is too far from the run colour to extend the run
  function automatic bit colour_breaks(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    longint unsigned r0, g0, b0, r1, g1, b1;
    longint unsigned dr, dg, db, t, a, n1, n2, dot;
    r0 = run_red;
    g0 = run_green;
    b0 = run_blue;
    r1 = r;
    g1 = g;
    b1 = b;
    dr = (r0 > r1) ? r0 - r1 : r1 - r0;
    dg = (g0 > g1) ? g0 - g1 : g1 - g0;
    db = (b0 > b1) ? b0 - b1 : b1 - b0;
    t  = thr_tenths;
    case (sim_mode)
      MODE_EUCLID: begin
        if (t > FULL_TENTHS) return 1'b1;
        a = FULL_TENTHS - t;
        return a * a * EUCLID_FULL < SQ_SCALE * (dr * dr + dg * dg + db * db);
      end
      MODE_MANH: begin
        return FULL_TENTHS * (MANH_FULL - (dr + dg + db)) < t * MANH_FULL;
      end
      MODE_COSINE: begin
        n1  = r0 * r0 + g0 * g0 + b0 * b0;
        n2  = r1 * r1 + g1 * g1 + b1 * b1;
        dot = r0 * r1 + g0 * g1 + b0 * b1;
        // a black pixel on either side counts as no similarity at all
        if (n1 == 0 || n2 == 0) return t > 0;
        return SQ_SCALE * dot * dot < t * t * n1 * n2;
      end
      default: return t > 0;
    endcase
  endfunction

  function automatic seg_item_t make_seg(input logic [11:0] first, input logic [11:0] last_col);
    seg_item_t item;
    item.last          = 1'b0;
    item.seg.seg_start = first;
    item.seg.seg_end   = last_col;
    item.seg.row       = row_count;
    item.seg.red       = run_red;
    item.seg.green     = run_green;
    item.seg.blue      = run_blue;
    return item;
  endfunction

  // Advance the run state by one pixel and queue the segments it closes
  task automatic segment_pixel(input logic [23:0] data, input logic frame_start);
    logic [7:0]  r, g, b;
    int unsigned eff_width;
    seg_item_t   segs [2];
    int          n;
    r = data[7:0];
    g = data[15:8];
    b = data[23:16];
    n = 0;
    eff_width = row_width;
    if (eff_width < 1) eff_width = 1;
    if (eff_width > WIDTH_LIMIT) eff_width = WIDTH_LIMIT;

    if (frame_start) begin
      column    = '0;
      row_count = '0;
    end

    if (column == 0) begin
      run_begin = '0;
      run_red   = r;
      run_green = g;
      run_blue  = b;
    end else if (colour_breaks(r, g, b)) begin
      segs[n] = make_seg(run_begin, column - 12'd1);
      n++;
      run_begin = column;
      run_red   = r;
      run_green = g;
      run_blue  = b;
    end

    if (column + 1 >= eff_width) begin
      segs[n] = make_seg(run_begin, column);
      n++;
      column = '0;
      if (row_count < ROW_LIMIT) row_count = row_count + 12'd1;
    end else begin
      column = column + 12'd1;
    end

    for (int k = 0; k < n; k++) begin
      segs[k].last = (k == n - 1);
      pending_segs = {pending_segs, segs[k]};
    end
  endtask

  // Compare one output transaction with the oldest prediction
  task automatic check_segment();
    seg_item_t want;
    if (pending_segs.size() == 0) begin
      report_mismatch("segment with none pending, seg_start", m_tdata[11:0], -1);
    end else begin
      want = pending_segs.pop_front();
      check_field("seg_start", m_tdata[11:0], want.seg.seg_start);
      check_field("seg_end", m_tdata[23:12], want.seg.seg_end);
      check_field("seg_row", m_tdata[35:24], want.seg.row);
      check_field("seg_red", m_tdata[43:36], want.seg.red);
      check_field("seg_green", m_tdata[51:44], want.seg.green);
      check_field("seg_blue", m_tdata[59:52], want.seg.blue);
      check_field("tdata padding", m_tdata[63:60], 0);
      check_field("last_of_run", m_tlast, want.last);
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      sim_mode   = MODE_RESET;
      thr_tenths = THRESHOLD_RESET;
      row_width  = WIDTH_RESET;
      run_begin  = '0;
      column     = '0;
      row_count  = '0;
      run_red    = '0;
      run_green  = '0;
      run_blue   = '0;
      pending_segs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:      sim_mode = cfg_data[1:0];
          REG_THRESHOLD: thr_tenths = cfg_data[9:0];
          REG_WIDTH:     row_width = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) segment_pixel(s_tdata, s_tuser);
      if (m_tvalid && m_tready) check_segment();
    end
    queued = pending_segs.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the colour run segmenter regression: clock, reset, pixel stimulus,
// output back-pressure and the verdict. Depends on crs_pkg, crs_checker and the RTL.
module tb_top;
  import crs_pkg::*;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          outstanding;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  logic [7:0]  last_red = '0;
  logic [7:0]  last_green = '0;
  logic [7:0]  last_blue = '0;

  color_run_segmenter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  crs_checker seg_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tlast     (m_axis_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop on a hung run
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // Output back-pressure: random stalls, plus a long hold when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one pixel after a random gap and hold it until the transaction
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic frame_start);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tuser  <= frame_start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    last_red   = r;
    last_green = g;
    last_blue  = b;
  endtask

  // Mostly drift from the previous pixel, sometimes jump or hit the extremes
  task automatic send_random_pixel(input logic frame_start);
    logic [7:0] comp [3];
    logic [7:0] prev [3];
    int         v;
    prev[0] = last_red;
    prev[1] = last_green;
    prev[2] = last_blue;
    case ($urandom_range(9))
      0, 1: begin
        for (int k = 0; k < 3; k++) comp[k] = 8'($urandom);
      end
      2: begin
        for (int k = 0; k < 3; k++) comp[k] = {8{1'($urandom_range(1))}};
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          v = int'(prev[k]) + int'($urandom_range(16)) - 8;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          comp[k] = v[7:0];
        end
      end
    endcase
    send_pixel(comp[0], comp[1], comp[2], frame_start);
  endtask

  // Stop offering and wait until the block has gone idle
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_config(input logic [1:0] mode, input logic [9:0] thr,
                              input logic [12:0] width);
    settle();
    write_reg(REG_MODE, {11'd0, mode});
    write_reg(REG_THRESHOLD, {3'd0, thr});
    write_reg(REG_WIDTH, width);
  endtask

  initial begin
    logic [1:0]  mode;
    logic [9:0]  thr;
    logic [12:0] width;
    int          guard;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: black to white breaks on manhattan distance
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

    // One-pixel rows
    settle();
    write_reg(REG_WIDTH, 13'd1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);

    // Zero width clamps to one
    settle();
    write_reg(REG_WIDTH, 13'd0);
    send_pixel(8'd170, 8'd85, 8'd170, 1'b0);
    send_pixel(8'd85, 8'd170, 8'd85, 1'b0);

    // Oversize width clamps to the limit; leave the row open
    settle();
    write_reg(REG_WIDTH, 13'h1FFF);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(8'd200, 8'd2, 8'd3, 1'b0);

    // Frame start drops the open run; threshold over full scale breaks every pixel
    apply_config(MODE_EUCLID, 10'h3FF, 13'd6);
    send_pixel(8'd10, 8'd10, 8'd10, 1'b1);
    send_pixel(8'd10, 8'd10, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd10, 8'd10, 1'b0);
    send_pixel(8'd10, 8'd10, 8'd10, 1'b0);

    // Narrow the row under the open run: the next pixel closes it
    settle();
    write_reg(REG_WIDTH, 13'd2);
    send_pixel(8'd10, 8'd10, 8'd10, 1'b0);

    // Cosine with a black pixel, at zero and mid threshold
    apply_config(MODE_COSINE, 10'd0, 13'd3);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd5, 8'd0, 8'd0, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, 13'd500);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd9, 8'd9, 8'd9, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);

    // Undefined mode: breaks on any non-zero threshold
    apply_config(MODE_UNDEF, 10'd1, 13'd3);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
    settle();
    write_reg(REG_THRESHOLD, 13'd0);
    send_pixel(8'd7, 8'd7, 8'd7, 1'b1);
    send_pixel(8'd9, 8'd9, 8'd9, 1'b0);

    // Random frames in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 8; blk++) begin
        mode = ($urandom_range(9) == 0) ? MODE_UNDEF : 2'($urandom_range(2));
        case ($urandom_range(7))
          0:       thr = 10'd0;
          1:       thr = FULL_TENTHS;
          2:       thr = 10'h3FF;
          3:       thr = 10'($urandom_range(1023));
          default: thr = 10'($urandom_range(999, 850));
        endcase
        case ($urandom_range(19))
          0:       width = 13'd0;
          1:       width = 13'h1FFF;
          2:       width = 13'd1;
          3:       width = 13'($urandom_range(40, 13));
          default: width = 13'($urandom_range(12, 2));
        endcase
        apply_config(mode, thr, width);
        for (int i = 0; i < 34; i++) begin
          send_random_pixel(i == 0 || $urandom_range(99) < 3);
          // long output stall while pixels keep coming
          if (phase == 0 && blk == 1 && i == 0) hold_left = HOLD_CYCLES;
        end
      end
    end

    // Drain and give the verdict
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    for (guard = 0; guard < 10000 && outstanding != 0; guard++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
